// File: src/mesh_duplicate_filter_defines.svh
// assertion macros used by the duplicate filter rtl
// depends on i_clk and i_rst_n being visible at the point of use
`ifndef MESH_DUPLICATE_FILTER_DEFINES_SVH
`define MESH_DUPLICATE_FILTER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MDF_CHECK_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define MDF_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mdf_pkg.sv
// shared types, codes and constants of the mesh duplicate filter
// no dependencies
`default_nettype none
package mdf_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int ADDR_W  = 48;
    localparam int MS_W    = 20;
    localparam int CAP_W   = 5;
    localparam int ACC_W   = 32;
    localparam int EL_W    = 16;
    localparam int IN_W    = 128;
    localparam int OUT_W   = 72;

    // configuration register indexes
    localparam logic [1:0] REG_OWN_ADDR = 2'd0;
    localparam logic [1:0] REG_INTERVAL = 2'd1;
    localparam logic [1:0] REG_LIFETIME = 2'd2;
    localparam logic [1:0] REG_CAPACITY = 2'd3;

    // result actions
    localparam logic [2:0] ACT_FOREIGN   = 3'd0;
    localparam logic [2:0] ACT_DUPLICATE = 3'd1;
    localparam logic [2:0] ACT_DELIVER   = 3'd2;
    localparam logic [2:0] ACT_DELIV_ACK = 3'd3;
    localparam logic [2:0] ACT_ACK_RECV  = 3'd4;
    localparam logic [2:0] ACT_DELIV_OTH = 3'd5;
    localparam logic [2:0] ACT_TICK_DONE = 3'd6;

    // command kinds decided by the front
    localparam logic [1:0] KIND_FOREIGN = 2'd0;
    localparam logic [1:0] KIND_PACKET  = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;

    // type classes
    localparam logic [1:0] CLS_PLAIN = 2'd0;
    localparam logic [1:0] CLS_CONF  = 2'd1;
    localparam logic [1:0] CLS_ACK   = 2'd2;
    localparam logic [1:0] CLS_OTHER = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        cls;
        logic [EL_W-1:0]   elapsed;
        logic [7:0]        id;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] tgt;
    } t_cmd;

    typedef struct packed {
        logic [7:0]        id;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] tgt;
        logic [1:0]        cls;
        logic [MS_W-1:0]   life;
    } t_entry;

    typedef struct packed {
        logic [2:0]        action;
        logic [7:0]        id;
        logic [ADDR_W-1:0] addr;
        logic [4:0]        expired;
        logic [4:0]        occupancy;
    } t_result;

    function automatic logic [1:0] class_of(input logic [7:0] ptype);
        logic [1:0] c;
        case (ptype)
            8'd0:    c = CLS_PLAIN;
            8'd1:    c = CLS_CONF;
            8'd3:    c = CLS_ACK;
            default: c = CLS_OTHER;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// File: src/mdf_front.sv
// front end: unpacks an input transaction and classifies it into a command
// depends on mdf_pkg
`default_nettype none
module mdf_front (
    input  wire logic                        i_mode,
    input  wire logic [mdf_pkg::IN_W-1:0]    i_data,
    input  wire logic [mdf_pkg::ADDR_W-1:0]  i_own_address,
    output mdf_pkg::t_cmd                    o_cmd
);

    logic [mdf_pkg::ADDR_W-1:0] tgt;

    assign tgt = i_data[127:80];

    always_comb begin
        o_cmd.elapsed = i_data[15:0];
        o_cmd.cls     = mdf_pkg::class_of(i_data[23:16]);
        o_cmd.id      = i_data[31:24];
        o_cmd.src     = i_data[79:32];
        o_cmd.tgt     = tgt;
        if (i_mode) begin
            o_cmd.kind = mdf_pkg::KIND_TICK;
        end else if (tgt != i_own_address) begin
            o_cmd.kind = mdf_pkg::KIND_FOREIGN;
        end else begin
            o_cmd.kind = mdf_pkg::KIND_PACKET;
        end
    end

endmodule
`default_nettype wire

// File: src/mdf_queue.sv
// two-entry command queue between front and back
// depends on mdf_pkg
`default_nettype none
module mdf_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire mdf_pkg::t_cmd i_cmd,
    output logic         o_full,
    input  wire logic    i_pop,
    output logic         o_valid,
    output mdf_pkg::t_cmd o_cmd
);

    mdf_pkg::t_cmd r_buf [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule
`default_nettype wire

// File: src/mdf_back.sv
// back end: seen-table engine with ring memory, lookup, record, aging,
// and the output register; depends on mdf_pkg and the defines header
`default_nettype none
`include "mesh_duplicate_filter_defines.svh"
module mdf_back #(
    parameter int CAPACITY = mdf_pkg::CAPACITY_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_valid,
    input  wire mdf_pkg::t_cmd               i_q_cmd,
    output logic                             o_q_pop,
    input  wire logic [mdf_pkg::MS_W-1:0]    i_interval,
    input  wire logic [mdf_pkg::MS_W-1:0]    i_lifetime,
    input  wire logic [mdf_pkg::CAP_W-1:0]   i_capacity,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output mdf_pkg::t_result                 o_result
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_REC  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    mdf_pkg::t_entry r_mem [CAPACITY];
    mdf_pkg::t_entry r_rdata;

    logic [2:0]                 r_state;
    logic                       r_aging;
    mdf_pkg::t_cmd              r_cmd;
    logic [IW-1:0]              r_oldest;
    logic [CW-1:0]              r_live;
    logic [CW-1:0]              r_k;
    logic [CW-1:0]              r_kept;
    logic [CW-1:0]              r_removed;
    logic [mdf_pkg::ACC_W-1:0]  r_acc;
    mdf_pkg::t_result           r_res;
    mdf_pkg::t_result           r_out;
    logic                       r_out_valid;

    logic [CW:0]                sum_k;
    logic [CW:0]                sum_kept;
    logic [CW:0]                sum_live;
    logic [IW-1:0]              slot_k;
    logic [IW-1:0]              slot_kept;
    logic [IW-1:0]              slot_live;
    logic [CW-1:0]              cap_eff;
    logic                       evict;
    logic [mdf_pkg::ACC_W:0]    acc_sum;
    logic [mdf_pkg::ACC_W-1:0]  acc_new;
    logic                       match;
    logic                       expired;
    logic                       rd_en;
    logic                       wr_en;
    logic [IW-1:0]              wr_addr;
    mdf_pkg::t_entry            wr_data;
    logic [2:0]                 rec_action;
    logic                       out_free;

    // ring positions, oldest + offset wraps at most once
    always_comb begin
        sum_k    = (CW+1)'(r_oldest) + {1'b0, r_k};
        sum_kept = (CW+1)'(r_oldest) + {1'b0, r_kept};
        sum_live = (CW+1)'(r_oldest) + {1'b0, r_live};
        if (32'(sum_k) >= CAPACITY) sum_k = sum_k - (CW+1)'(CAPACITY);
        if (32'(sum_kept) >= CAPACITY) sum_kept = sum_kept - (CW+1)'(CAPACITY);
        if (32'(sum_live) >= CAPACITY) sum_live = sum_live - (CW+1)'(CAPACITY);
        slot_k    = sum_k[IW-1:0];
        slot_kept = sum_kept[IW-1:0];
        slot_live = sum_live[IW-1:0];
    end

    always_comb begin
        if (i_capacity == '0) begin
            cap_eff = CW'(1);
        end else if (32'(i_capacity) > CAPACITY) begin
            cap_eff = CW'(CAPACITY);
        end else begin
            cap_eff = CW'(i_capacity);
        end
        evict = (32'(r_live) >= 32'(cap_eff)) && (r_live != '0);
    end

    always_comb begin
        acc_sum = {1'b0, r_acc} + (mdf_pkg::ACC_W+1)'(i_q_cmd.elapsed);
        acc_new = acc_sum[mdf_pkg::ACC_W] ? '1 : acc_sum[mdf_pkg::ACC_W-1:0];
    end

    always_comb begin
        match = (r_rdata.life != '0) && (r_rdata.id == r_cmd.id) &&
                (r_rdata.src == r_cmd.src) && (r_rdata.tgt == r_cmd.tgt) &&
                (r_rdata.cls == r_cmd.cls);
        expired = (mdf_pkg::ACC_W'(r_rdata.life) <= r_acc);
    end

    always_comb begin
        case (r_cmd.cls)
            mdf_pkg::CLS_PLAIN: rec_action = mdf_pkg::ACT_DELIVER;
            mdf_pkg::CLS_CONF:  rec_action = mdf_pkg::ACT_DELIV_ACK;
            mdf_pkg::CLS_ACK:   rec_action = mdf_pkg::ACT_ACK_RECV;
            default:            rec_action = mdf_pkg::ACT_DELIV_OTH;
        endcase
    end

    // table write: compaction during aging or a new record
    always_comb begin
        rd_en = (r_state == S_RD) && (r_k != r_live);
        wr_en = 1'b0;
        wr_addr = slot_live;
        wr_data.id   = r_cmd.id;
        wr_data.src  = r_cmd.src;
        wr_data.tgt  = r_cmd.tgt;
        wr_data.cls  = r_cmd.cls;
        wr_data.life = i_lifetime;
        if (r_state == S_REC) begin
            wr_en = 1'b1;
        end else if ((r_state == S_CMP) && r_aging && !expired) begin
            wr_en   = 1'b1;
            wr_addr = slot_kept;
            wr_data = r_rdata;
            wr_data.life = r_rdata.life - r_acc[mdf_pkg::MS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[slot_k];
        end
    end

    assign out_free = !r_out_valid || i_ready;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if ((r_state == S_OUT) && out_free) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_aging     <= 1'b0;
            r_oldest    <= '0;
            r_live      <= '0;
            r_k         <= '0;
            r_kept      <= '0;
            r_removed   <= '0;
            r_acc       <= '0;
            r_res       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_k       <= '0;
                        r_kept    <= '0;
                        r_removed <= '0;
                        r_res.expired   <= '0;
                        r_res.occupancy <= 5'(r_live);
                        case (i_q_cmd.kind)
                            mdf_pkg::KIND_TICK: begin
                                r_res.action <= mdf_pkg::ACT_TICK_DONE;
                                r_res.id     <= '0;
                                r_res.addr   <= '0;
                                r_acc        <= acc_new;
                                if (acc_new >= mdf_pkg::ACC_W'(i_interval)) begin
                                    r_aging <= 1'b1;
                                    r_state <= S_RD;
                                end else begin
                                    r_state <= S_OUT;
                                end
                            end
                            mdf_pkg::KIND_PACKET: begin
                                r_res.action <= mdf_pkg::ACT_FOREIGN;
                                r_res.id     <= i_q_cmd.id;
                                r_res.addr   <= i_q_cmd.src;
                                r_aging      <= 1'b0;
                                r_state      <= S_RD;
                            end
                            default: begin
                                r_res.action <= mdf_pkg::ACT_FOREIGN;
                                r_res.id     <= i_q_cmd.id;
                                r_res.addr   <= i_q_cmd.src;
                                r_state      <= S_OUT;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    if (r_k == r_live) begin
                        if (r_aging) begin
                            r_live  <= r_kept;
                            r_acc   <= '0;
                            r_res.expired   <= 5'(r_removed);
                            r_res.occupancy <= 5'(r_kept);
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_REC;
                        end
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_k <= r_k + CW'(1);
                    if (r_aging) begin
                        r_state <= S_RD;
                        if (expired) begin
                            r_removed <= r_removed + CW'(1);
                        end else begin
                            r_kept <= r_kept + CW'(1);
                        end
                    end else if (match) begin
                        r_res.action <= mdf_pkg::ACT_DUPLICATE;
                        r_state      <= S_OUT;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_REC: begin
                    // eviction drops the oldest; the new entry lands at oldest + live
                    if (evict) begin
                        r_oldest <= (32'(r_oldest) == CAPACITY - 1) ? '0 :
                                    r_oldest + IW'(1);
                        r_res.occupancy <= 5'(r_live);
                    end else begin
                        r_live <= r_live + CW'(1);
                        r_res.occupancy <= 5'(r_live + CW'(1));
                    end
                    r_res.action <= rec_action;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `MDF_CHECK_NOW(a_live_bound, 1'b1, 32'(r_live) <= CAPACITY, "live count above capacity")
    `MDF_CHECK_NOW(a_cmp_after_rd, r_state == S_CMP, $past(r_state) == S_RD, "compare without read")
    `MDF_CHECK_NEXT(a_rec_nonempty, r_state == S_REC, r_live != '0, "table empty after record")
    `MDF_CHECK_NOW(a_kept_bound, r_aging && (r_state == S_RD), r_kept + r_removed == r_k,
        "aging counters out of step")

endmodule
`default_nettype wire

// File: src/mesh_duplicate_filter.sv
// Mesh duplicate filter. Each input transaction is a packet header or a time
// tick; each produces exactly one result transaction. A packet for this
// station is compared against the seen table one entry at a time through
// the table memory's single read port, each entry fetched then compared,
// and, if none matches, is then recorded and reported. An aging tick walks
// every held entry the same way. A two-entry queue behind the input and a
// result register let the input keep accepting while a result waits.
// Configuration is written through a plain write port; the user must write
// it only while idle, the block itself does not enforce this. Table entries
// live in a ring of CAPACITY slots and need no clearing.
`default_nettype none
module mesh_duplicate_filter #(
    parameter int CAPACITY = mdf_pkg::CAPACITY_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // elapsed_ms[15:0], packet_type[23:16], packet_id[31:24],
    // source_address[79:32], target_address[127:80]
    input  wire logic [mdf_pkg::IN_W-1:0]     i_s_axis_tdata,
    // mode[0]
    input  wire logic                         i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  wire logic                         i_m_axis_tready,
    // reply_id[7:0], reply_address[55:8], expired_count[60:56],
    // occupancy[65:61], zero[71:66]
    output logic [mdf_pkg::OUT_W-1:0]         o_m_axis_tdata,
    // action[2:0]
    output logic [2:0]                        o_m_axis_tuser,
    input  wire logic                         i_cfg_we,
    input  wire logic [1:0]                   i_cfg_index,
    input  wire logic [mdf_pkg::ADDR_W-1:0]   i_cfg_data
);

    logic [mdf_pkg::ADDR_W-1:0] r_own;
    logic [mdf_pkg::MS_W-1:0]   r_interval;
    logic [mdf_pkg::MS_W-1:0]   r_lifetime;
    logic [mdf_pkg::CAP_W-1:0]  r_capacity;

    mdf_pkg::t_cmd    front_cmd;
    mdf_pkg::t_cmd    q_cmd;
    mdf_pkg::t_result result;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic             push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own      <= '0;
            r_interval <= mdf_pkg::MS_W'(1000);
            r_lifetime <= mdf_pkg::MS_W'(10000);
            r_capacity <= mdf_pkg::CAP_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mdf_pkg::REG_OWN_ADDR: r_own      <= i_cfg_data;
                mdf_pkg::REG_INTERVAL: r_interval <= i_cfg_data[mdf_pkg::MS_W-1:0];
                mdf_pkg::REG_LIFETIME: r_lifetime <= i_cfg_data[mdf_pkg::MS_W-1:0];
                mdf_pkg::REG_CAPACITY: r_capacity <= i_cfg_data[mdf_pkg::CAP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = !q_full;
    assign push = i_s_axis_tvalid && !q_full;

    mdf_front u_front (
        .i_mode        (i_s_axis_tuser),
        .i_data        (i_s_axis_tdata),
        .i_own_address (r_own),
        .o_cmd         (front_cmd)
    );

    mdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    mdf_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .i_interval (r_interval),
        .i_lifetime (r_lifetime),
        .i_capacity (r_capacity),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_result   (result)
    );

    assign o_m_axis_tuser = result.action;
    assign o_m_axis_tdata = {6'b0, result.occupancy, result.expired, result.addr, result.id};

endmodule
`default_nettype wire

// File: tb/sv/mesh_duplicate_filter_checker.sv
// result checker for the mesh duplicate filter testbench
// keeps its own copy of the seen table and settings, depends on mdf_pkg
`timescale 1ns / 100ps
`default_nettype none
module mesh_duplicate_filter_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    input  wire logic         i_s_tready,
    input  wire logic [127:0] i_s_tdata,
    input  wire logic         i_s_tuser,
    input  wire logic         i_m_tvalid,
    input  wire logic         i_m_tready,
    input  wire logic [71:0]  i_m_tdata,
    input  wire logic [2:0]   i_m_tuser,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [47:0]  i_cfg_data,
    output int                o_errors,
    output int                o_pending
);

    localparam int SLOTS = 16;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  id;
        logic [47:0] addr;
        logic [4:0]  expired;
        logic [4:0]  occupancy;
    } t_verdict;

    // settings copy
    logic [47:0] own_addr;
    logic [19:0] interval_ms;
    logic [19:0] lifetime_ms;
    logic [4:0]  cap_reg;

    // seen table ring
    logic [7:0]  tbl_id [SLOTS];
    logic [47:0] tbl_src [SLOTS];
    logic [47:0] tbl_tgt [SLOTS];
    logic [1:0]  tbl_cls [SLOTS];
    int unsigned tbl_life [SLOTS];
    int unsigned head;
    int unsigned held;
    longint unsigned acc_ms;

    t_verdict expected_results[$];
    int errors;

    assign o_errors  = errors;
    assign o_pending = expected_results.size();

    function automatic logic [1:0] type_class(input logic [7:0] t);
        if (t == 8'd0) return mdf_pkg::CLS_PLAIN;
        if (t == 8'd1) return mdf_pkg::CLS_CONF;
        if (t == 8'd3) return mdf_pkg::CLS_ACK;
        return mdf_pkg::CLS_OTHER;
    endfunction

    // compacts the ring in age order, returns number removed
    function automatic int unsigned age_entries(input longint unsigned dt);
        int unsigned kept, removed, s, d;
        kept = 0;
        removed = 0;
        for (int unsigned k = 0; k < held; k++) begin
            s = (head + k) % SLOTS;
            if (tbl_life[s] <= dt) begin
                removed++;
            end else begin
                d = (head + kept) % SLOTS;
                tbl_id[d]   = tbl_id[s];
                tbl_src[d]  = tbl_src[s];
                tbl_tgt[d]  = tbl_tgt[s];
                tbl_cls[d]  = tbl_cls[s];
                tbl_life[d] = 32'(tbl_life[s] - dt);
                kept++;
            end
        end
        held = kept;
        return removed;
    endfunction

    function automatic t_verdict filter_step(input logic mode, input logic [127:0] d);
        t_verdict v;
        logic [15:0] el;
        logic [7:0]  ptype, pid;
        logic [47:0] src, tgt;
        logic [1:0]  cls;
        int unsigned cap, s;
        bit hit;
        el    = d[15:0];
        ptype = d[23:16];
        pid   = d[31:24];
        src   = d[79:32];
        tgt   = d[127:80];
        v = '0;
        if (mode) begin
            acc_ms = acc_ms + el;
            if (acc_ms > 64'hFFFF_FFFF) acc_ms = 64'hFFFF_FFFF;
            v.action = mdf_pkg::ACT_TICK_DONE;
            if (acc_ms >= interval_ms) begin
                v.expired = 5'(age_entries(acc_ms));
                acc_ms = 0;
            end
            v.occupancy = 5'(held);
            return v;
        end
        v.id = pid;
        v.addr = src;
        if (tgt != own_addr) begin
            v.action = mdf_pkg::ACT_FOREIGN;
            v.occupancy = 5'(held);
            return v;
        end
        cls = type_class(ptype);
        hit = 0;
        for (int unsigned k = 0; k < held; k++) begin
            s = (head + k) % SLOTS;
            if (tbl_life[s] > 0 && tbl_id[s] == pid && tbl_src[s] == src &&
                tbl_tgt[s] == tgt && tbl_cls[s] == cls) hit = 1;
        end
        if (hit) begin
            v.action = mdf_pkg::ACT_DUPLICATE;
            v.occupancy = 5'(held);
            return v;
        end
        cap = cap_reg;
        if (cap < 1) cap = 1;
        if (cap > SLOTS) cap = SLOTS;
        if (held >= cap && held > 0) begin
            head = (head + 1) % SLOTS;
            held--;
        end
        s = (head + held) % SLOTS;
        tbl_id[s] = pid;
        tbl_src[s] = src;
        tbl_tgt[s] = tgt;
        tbl_cls[s] = cls;
        tbl_life[s] = lifetime_ms;
        held++;
        case (cls)
            mdf_pkg::CLS_PLAIN: v.action = mdf_pkg::ACT_DELIVER;
            mdf_pkg::CLS_CONF:  v.action = mdf_pkg::ACT_DELIV_ACK;
            mdf_pkg::CLS_ACK:   v.action = mdf_pkg::ACT_ACK_RECV;
            default:            v.action = mdf_pkg::ACT_DELIV_OTH;
        endcase
        v.occupancy = 5'(held);
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            own_addr    = '0;
            interval_ms = 20'd1000;
            lifetime_ms = 20'd10000;
            cap_reg     = 5'd16;
            head = 0;
            held = 0;
            acc_ms = 0;
            errors = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mdf_pkg::REG_OWN_ADDR: own_addr    = i_cfg_data;
                    mdf_pkg::REG_INTERVAL: interval_ms = i_cfg_data[19:0];
                    mdf_pkg::REG_LIFETIME: lifetime_ms = i_cfg_data[19:0];
                    mdf_pkg::REG_CAPACITY: cap_reg     = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                expected_results = {expected_results, filter_step(i_s_tuser, i_s_tdata)};
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction, action %0d", i_m_tuser);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_m_tuser != want.action) begin
                        $error("action expected %0d got %0d", want.action, i_m_tuser);
                        errors++;
                    end
                    if (i_m_tdata[7:0] != want.id) begin
                        $error("reply_id expected %0d got %0d", want.id, i_m_tdata[7:0]);
                        errors++;
                    end
                    if (i_m_tdata[55:8] != want.addr) begin
                        $error("reply_address expected %h got %h", want.addr,
                               i_m_tdata[55:8]);
                        errors++;
                    end
                    if (i_m_tdata[60:56] != want.expired) begin
                        $error("expired_count expected %0d got %0d", want.expired,
                               i_m_tdata[60:56]);
                        errors++;
                    end
                    if (i_m_tdata[65:61] != want.occupancy) begin
                        $error("occupancy expected %0d got %0d", want.occupancy,
                               i_m_tdata[65:61]);
                        errors++;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: tb/sv/mesh_duplicate_filter_test.sv
// top of the mesh duplicate filter testbench: clock, reset, stimulus, verdict
// depends on mdf_pkg, mesh_duplicate_filter and mesh_duplicate_filter_checker
`timescale 1ns / 100ps
`default_nettype none
module mesh_duplicate_filter_test;

    localparam int STALL_LIMIT = 3000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic [127:0] s_data = '0;
    logic         s_user = 1'b0;
    logic         m_ready = 1'b1;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = mdf_pkg::REG_OWN_ADDR;
    logic [47:0]  cfg_data = '0;
    logic         s_ready, m_valid;
    logic [71:0]  m_data;
    logic [2:0]   m_user;
    int           errors, pending;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           quiet_cycles = 0;
    logic [47:0]  station;
    logic [47:0]  peers[4];
    logic [127:0] recent_headers[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    mesh_duplicate_filter DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    mesh_duplicate_filter_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .i_s_tready(s_ready), .i_s_tdata(s_data),
        .i_s_tuser(s_user), .i_m_tvalid(m_valid), .i_m_tready(m_ready),
        .i_m_tdata(m_data), .i_m_tuser(m_user), .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_item(input logic mode, input logic [127:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user <= mode;
        s_data <= d;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
    endtask

    task automatic send_header(input logic [7:0] ptype, input logic [7:0] pid,
                               input logic [47:0] src, input logic [47:0] tgt);
        logic [127:0] d;
        d = {tgt, src, pid, ptype, 16'($urandom)};
        send_item(1'b0, d);
        if (tgt == station) begin
            recent_headers = {recent_headers, d};
            if (recent_headers.size() > 8) void'(recent_headers.pop_front());
        end
    endtask

    task automatic send_tick(input logic [15:0] el);
        send_item(1'b1, {112'({$urandom, $urandom, $urandom, $urandom}), el});
    endtask

    // lets the block go quiet before touching settings
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(input logic [47:0] addr, input logic [19:0] ivl,
                                  input logic [19:0] life, input logic [47:0] cap);
        settle();
        write_reg(mdf_pkg::REG_OWN_ADDR, addr);
        write_reg(mdf_pkg::REG_INTERVAL, {28'd0, ivl});
        write_reg(mdf_pkg::REG_LIFETIME, {28'd0, life});
        write_reg(mdf_pkg::REG_CAPACITY, cap);
        station = addr;
    endtask

    task automatic random_item(input int ivl);
        int r;
        logic [127:0] d;
        r = $urandom_range(99);
        if (r < 15) begin
            if ($urandom_range(4) == 0) send_tick(16'($urandom));
            else send_tick(16'($urandom_range(0, ivl / 3 + 20)));
        end else if (r < 25) begin
            send_header(8'($urandom), 8'($urandom), 48'({$urandom, $urandom}),
                        48'({$urandom, $urandom}));
        end else if (r < 50 && recent_headers.size() > 0) begin
            d = recent_headers[$urandom_range(recent_headers.size() - 1)];
            // same class, other type byte, still a match
            if (d[23:16] > 8'd3 && $urandom_range(1)) d[23:16] = 8'($urandom_range(4, 255));
            send_item(1'b0, d);
        end else begin
            case ($urandom_range(4))
                0: r = 0;
                1: r = 1;
                2: r = 3;
                3: r = 2;
                default: r = $urandom_range(0, 255);
            endcase
            send_header(8'(r), 8'($urandom_range(0, 7)),
                        $urandom_range(1) ? peers[$urandom_range(3)]
                                          : 48'({$urandom, $urandom}), station);
        end
    endtask

    initial begin
        int ivls[8];
        int lives[8];
        int caps[8];
        for (int i = 0; i < 4; i++) peers[i] = 48'({$urandom, $urandom});
        station = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: own address zero
        send_header(8'd0, 8'd0, 48'd0, 48'd0);
        send_header(8'd1, 8'd255, 48'hFFFF_FFFF_FFFF, 48'd0);
        send_header(8'd3, 8'd7, peers[0], 48'd0);
        send_header(8'd2, 8'd7, peers[0], 48'd0);
        send_header(8'd255, 8'd7, peers[0], 48'd0);
        send_header(8'd0, 8'd0, 48'd0, 48'd0);
        send_header(8'd200, 8'd7, peers[0], 48'd0);
        send_header(8'd0, 8'd1, peers[1], 48'hFFFF_FFFF_FFFF);
        send_tick(16'd0);
        send_tick(16'd999);
        send_tick(16'd1);
        send_header(8'd1, 8'd255, 48'hFFFF_FFFF_FFFF, 48'd0);
        send_tick(16'hFFFF);
        // zero interval, zero lifetime, capacity below range
        apply_settings(48'hFFFF_FFFF_FFFF, 20'd0, 20'd0, 48'd0);
        send_header(8'd0, 8'd9, peers[2], 48'hFFFF_FFFF_FFFF);
        send_header(8'd0, 8'd9, peers[2], 48'hFFFF_FFFF_FFFF);
        send_header(8'd3, 8'd9, peers[2], 48'hFFFF_FFFF_FFFF);
        send_tick(16'd0);
        // capacity above range, long lifetime, fill then lower capacity
        apply_settings(48'hFFFF_FFFF_FFFF, 20'hFFFFF, 20'hFFFFF, 48'd31);
        for (int i = 0; i < 18; i++)
            send_header(8'd0, 8'(i), peers[3], 48'hFFFF_FFFF_FFFF);
        apply_settings(48'hFFFF_FFFF_FFFF, 20'hFFFFF, 20'hFFFFF, 48'd3);
        send_header(8'd1, 8'd100, peers[3], 48'hFFFF_FFFF_FFFF);

        ivls  = '{200, 0, 1048575, 50, 1000, 30, 500, 100};
        lives = '{300, 1, 1048575, 120, 10000, 0, 800, 250};
        caps  = '{16, 1, 16, 5, 0, 8, 31, 12};
        for (int p = 0; p < 8; p++) begin
            apply_settings(p == 2 ? 48'h0 : 48'({$urandom, $urandom}),
                           20'(ivls[p]), 20'(lives[p]), 48'(caps[p]));
            recent_headers.delete();
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            for (int n = 0; n < 80; n++) random_item(ivls[p]);
        end

        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+src
src/mdf_pkg.sv
src/mdf_front.sv
src/mdf_queue.sv
src/mdf_back.sv
src/mesh_duplicate_filter.sv
tb/sv/mesh_duplicate_filter_checker.sv
tb/sv/mesh_duplicate_filter_test.sv
